// ===== src/aes_pkg.sv =====
// Package for the AES-128 encrypt block: state types, constants,
// S-box and round helper functions. No dependencies.
package aes_pkg;

	localparam int KeyCount = 11;
	localparam int LastRound = 10;
	localparam int RoundW = 4;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_ENCRYPT = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_KEY0,
		ST_ROUND,
		ST_DONE
	} aes_state_t;

	function automatic logic [7:0] sbox(input logic [7:0] x);
		logic [7:0] s [256];
		s = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
		};
		return s[x];
	endfunction

	function automatic logic [7:0] xtime(input logic [7:0] x);
		return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
	endfunction

	// Byte i of the state sits at bits 127-8i.
	function automatic logic [7:0] get_byte(input logic [127:0] s, input int i);
		return s[127 - 8 * i -: 8];
	endfunction

	// SubBytes, ShiftRows and, unless last, MixColumns on a 128-bit state.
	function automatic logic [127:0] round_fn(input logic [127:0] s, input logic last);
		logic [7:0] t [16];
		logic [7:0] a0, a1, a2, a3, al;
		logic [127:0] r;
		r = '0;
		for (int c = 0; c < 4; c++) begin
			for (int q = 0; q < 4; q++) begin
				t[4 * c + q] = sbox(get_byte(s, 4 * ((c + q) % 4) + q));
			end
		end
		for (int c = 0; c < 4; c++) begin
			a0 = t[4 * c];
			a1 = t[4 * c + 1];
			a2 = t[4 * c + 2];
			a3 = t[4 * c + 3];
			al = a0 ^ a1 ^ a2 ^ a3;
			if (!last) begin
				t[4 * c] = a0 ^ al ^ xtime(a0 ^ a1);
				t[4 * c + 1] = a1 ^ al ^ xtime(a1 ^ a2);
				t[4 * c + 2] = a2 ^ al ^ xtime(a2 ^ a3);
				t[4 * c + 3] = a3 ^ al ^ xtime(a3 ^ a0);
			end
		end
		for (int i = 0; i < 16; i++) begin
			r[127 - 8 * i -: 8] = t[i];
		end
		return r;
	endfunction

endpackage

// ===== src/aes_ram.sv =====
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
module aes_ram #(
	parameter int Width = 128,
	parameter int Depth = 11
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== src/aes128_encrypt_block.sv =====
// AES-128 ECB encrypt block with round key store and one shared round unit.
// Depends on aes_pkg and aes_ram.
//
// Usage: one input channel (in_valid / in_stall) carries a word with an
// operation bit, a key index and a 128-bit payload as two 64-bit halves.
// A load word (operation 0) writes round key key_index (0 to 10) into the
// key store and gives no result; indexes 11 to 15 are dropped. An encrypt
// word (operation 1) holds the plaintext. The block raises in_stall while
// it works on a block: it fetches round key 0, then performs the initial
// AddRoundKey and ten rounds in turn, each round sharing the single round
// unit and the key store read port. The ciphertext is then registered from
// the final round onto the output channel (out_valid / out_stall). With no
// output stall it is taken at once; the next word can be accepted only
// after the result has been taken, so output stalls delay it. While the
// receiver stalls, the result stays stable and no new word is taken. Reset
// (arst_n low) clears the sequencer and out_valid; the key store is not
// cleared, so every round key must be loaded before use. Loads are
// accepted back to back whenever the block is idle.
module aes128_encrypt_block
	import aes_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        operation,
	input  logic [3:0]  key_index,
	input  logic [63:0] word_high,
	input  logic [63:0] word_low,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] cipher_high,
	output logic [63:0] cipher_low
);
	aes_state_t state_q, state_d;
	logic [RoundW-1:0] round_q, round_d;
	logic [127:0] blk_q;
	logic [127:0] key_rd;
	logic [127:0] round_out;
	logic [RoundW-1:0] raddr;
	logic in_acc, key_we, out_busy;

	assign out_busy = out_valid && out_stall;
	assign in_stall = (state_q != ST_IDLE) || out_busy;
	assign in_acc = in_valid && !in_stall;
	assign key_we = in_acc && (operation == OP_LOAD) && (key_index < RoundW'(KeyCount));

	aes_ram #(.Width(128), .Depth(KeyCount)) u_keys (
		.clk(clk),
		.we(key_we),
		.waddr(key_index),
		.wdata({word_high, word_low}),
		.raddr(raddr),
		.rdata(key_rd)
	);

	// The shared round unit: SubBytes, ShiftRows, MixColumns except in the
	// final round, then AddRoundKey.
	assign round_out = round_fn(blk_q, round_q == RoundW'(LastRound)) ^ key_rd;

	// Read address leads the round counter by one so data arrives in time.
	always_comb begin
		state_d = state_q;
		round_d = round_q;
		raddr = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_acc && operation == OP_ENCRYPT) begin
					state_d = ST_KEY0;
					round_d = '0;
				end
			end
			ST_KEY0: begin
				raddr = '0;
				state_d = ST_ROUND;
			end
			ST_ROUND: begin
				if (round_q != RoundW'(LastRound)) begin
					raddr = round_q + RoundW'(1);
				end
				round_d = round_q + RoundW'(1);
				if (round_q == RoundW'(LastRound)) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!out_busy) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			round_q <= '0;
		end else begin
			state_q <= state_d;
			round_q <= round_d;
		end
	end

	// Round 0 is AddRoundKey alone; rounds 1..10 go through the round unit.
	always_ff @(posedge clk) begin
		if (in_acc && operation == OP_ENCRYPT) begin
			blk_q <= {word_high, word_low};
		end else if (state_q == ST_ROUND) begin
			if (round_q == '0) begin
				blk_q <= blk_q ^ key_rd;
			end else begin
				blk_q <= round_out;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (state_q == ST_ROUND && round_q == RoundW'(LastRound)) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && !out_busy && !out_valid) begin
			cipher_high <= blk_q[127:64];
			cipher_low <= blk_q[63:0];
		end else if (state_q == ST_ROUND && round_q == RoundW'(LastRound)) begin
			cipher_high <= round_out[127:64];
			cipher_low <= round_out[63:0];
		end
	end

	a_no_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ROUND) |-> in_stall)
		else $error("input taken during rounds");
	a_valid_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ROUND && round_q == RoundW'(LastRound)) |=> out_valid)
		else $error("result not raised after final round");
	a_round_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ROUND) |-> (round_q <= RoundW'(LastRound)))
		else $error("round counter overran");
endmodule

// ===== bench/aes128_encrypt_block_test.sv =====
// Self-checking testbench for the AES-128 ECB encrypt block: round key loads
// and block encryptions with random gaps and output stalls. Depends on aes_pkg and aes128_encrypt_block.
`timescale 1ns / 100ps

module aes128_encrypt_block_test
	import aes_pkg::*;
;

	// One input word as the driver presents it.
	typedef struct packed {
		logic        op;
		logic [3:0]  kidx;
		logic [63:0] hi;
		logic [63:0] lo;
	} aes_word_t;

	localparam int CycleLimit = 400000;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic operation;
	logic [3:0] key_index;
	logic [63:0] word_high;
	logic [63:0] word_low;
	logic out_valid;
	logic out_stall;
	logic [63:0] cipher_high;
	logic [63:0] cipher_low;

	aes_word_t pending_words[$];
	logic [127:0] expected_cipher[$];
	logic [127:0] key_sched[KeyCount];
	int error_count;
	int cycle_count;

	aes128_encrypt_block uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.operation(operation),
		.key_index(key_index),
		.word_high(word_high),
		.word_low(word_low),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.cipher_high(cipher_high),
		.cipher_low(cipher_low)
	);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	// The predictor keeps its own S-box table, built independently:
	// it derives the AES S-box from GF(2^8) inversion plus the affine map,
	// so it shares no code with the package.
	logic [7:0] sub_table[256];

	function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] p;
		p = 8'h00;
		for (int i = 0; i < 8; i++) begin
			if (b[i]) begin
				p = p ^ a;
			end
			a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
		end
		return p;
	endfunction

	function automatic logic [7:0] affine_of_inverse(input logic [7:0] x);
		logic [7:0] inv;
		logic [7:0] r;
		inv = 8'h00;
		for (int c = 1; c < 256; c++) begin
			if (gf_mul(x, 8'(c)) == 8'h01) begin
				inv = 8'(c);
			end
		end
		for (int i = 0; i < 8; i++) begin
			r[i] = inv[i] ^ inv[(i + 4) % 8] ^ inv[(i + 5) % 8] ^ inv[(i + 6) % 8]
				^ inv[(i + 7) % 8];
		end
		return r ^ 8'h63;
	endfunction

	// Full AES-128 encryption of one block with the current key schedule.
	// Byte i of a 128-bit value sits at bits 127-8i.
	function automatic logic [127:0] encipher(input logic [127:0] plain);
		logic [7:0] st[16];
		logic [7:0] tmp[16];
		logic [7:0] a0, a1, a2, a3, sum;
		logic [127:0] res;
		for (int i = 0; i < 16; i++) begin
			st[i] = plain[127 - 8 * i -: 8] ^ key_sched[0][127 - 8 * i -: 8];
		end
		for (int rnd = 1; rnd <= LastRound; rnd++) begin
			// SubBytes and ShiftRows together.
			for (int c = 0; c < 4; c++) begin
				for (int r = 0; r < 4; r++) begin
					tmp[4 * c + r] = sub_table[st[4 * ((c + r) % 4) + r]];
				end
			end
			if (rnd != LastRound) begin
				for (int c = 0; c < 4; c++) begin
					a0 = tmp[4 * c];
					a1 = tmp[4 * c + 1];
					a2 = tmp[4 * c + 2];
					a3 = tmp[4 * c + 3];
					sum = a0 ^ a1 ^ a2 ^ a3;
					tmp[4 * c] = a0 ^ sum ^ gf_mul(a0 ^ a1, 8'h02);
					tmp[4 * c + 1] = a1 ^ sum ^ gf_mul(a1 ^ a2, 8'h02);
					tmp[4 * c + 2] = a2 ^ sum ^ gf_mul(a2 ^ a3, 8'h02);
					tmp[4 * c + 3] = a3 ^ sum ^ gf_mul(a3 ^ a0, 8'h02);
				end
			end
			for (int i = 0; i < 16; i++) begin
				st[i] = tmp[i] ^ key_sched[rnd][127 - 8 * i -: 8];
			end
		end
		for (int i = 0; i < 16; i++) begin
			res[127 - 8 * i -: 8] = st[i];
		end
		return res;
	endfunction

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	// Mostly short gaps, now and then a long one, and often none at all.
	function automatic int gap_length();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 55) begin
			return 0;
		end else if (roll < 93) begin
			return $urandom_range(1, 3);
		end else begin
			return $urandom_range(10, 40);
		end
	endfunction

	task automatic push_word(input logic op, input logic [3:0] kidx,
			input logic [63:0] hi, input logic [63:0] lo);
		aes_word_t w;
		w.op = op;
		w.kidx = kidx;
		w.hi = hi;
		w.lo = lo;
		pending_words.push_back(w);
	endtask

	task automatic push_schedule(input logic [127:0] first_key);
		push_word(OP_LOAD, 4'd0, first_key[127:64], first_key[63:0]);
		for (int k = 1; k < KeyCount; k++) begin
			push_word(OP_LOAD, 4'(k), rand64(), rand64());
		end
	endtask

	// Driver: presents queued words, holds a word steady while stalled and
	// inserts random idle gaps between words.
	int drive_gap;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			operation <= OP_LOAD;
			key_index <= 4'd0;
			word_high <= 64'd0;
			word_low <= 64'd0;
			drive_gap <= 0;
		end else begin
			if (!in_valid || !in_stall) begin
				// Predict on acceptance, in order of acceptance.
				if (in_valid) begin
					if (operation == OP_LOAD) begin
						if (key_index < KeyCount) begin
							key_sched[key_index] <= {word_high, word_low};
						end
					end else begin
						expected_cipher.push_back(encipher({word_high, word_low}));
					end
				end
				if (drive_gap > 0) begin
					in_valid <= 1'b0;
					drive_gap <= drive_gap - 1;
				end else if (pending_words.size() > 0) begin
					in_valid <= 1'b1;
					operation <= pending_words[0].op;
					key_index <= pending_words[0].kidx;
					word_high <= pending_words[0].hi;
					word_low <= pending_words[0].lo;
					void'(pending_words.pop_front());
					drive_gap <= gap_length();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// A load followed at once by an encrypt must see the new key, so the
	// schedule copy above is written with a nonblocking assignment and read
	// one word later; the encrypt word is accepted at a later edge than
	// the load, by which time the copy has been updated.

	// Monitor: random stalls on the output side and a check of every
	// accepted result against the oldest expected ciphertext.
	int stall_left;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_cipher.size() == 0) begin
					$display("%0t: unexpected result %h_%h", $realtime, cipher_high,
						cipher_low);
					error_count++;
				end else begin
					if (cipher_high !== expected_cipher[0][127:64]) begin
						$display("%0t: cipher_high expected %h actual %h", $realtime,
							expected_cipher[0][127:64], cipher_high);
						error_count++;
					end
					if (cipher_low !== expected_cipher[0][63:0]) begin
						$display("%0t: cipher_low expected %h actual %h", $realtime,
							expected_cipher[0][63:0], cipher_low);
						error_count++;
					end
					void'(expected_cipher.pop_front());
				end
			end
			if (stall_left > 0) begin
				out_stall <= 1'b1;
				stall_left <= stall_left - 1;
			end else begin
				out_stall <= 1'b0;
				stall_left <= gap_length();
			end
		end
	end

	// Watchdog on the cycle count.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CycleLimit) begin
			$display("aes128_encrypt_block verification failed");
			$finish;
		end
	end

	initial begin
		in_valid = 1'b0;
		operation = OP_LOAD;
		key_index = 4'd0;
		word_high = 64'd0;
		word_low = 64'd0;
		out_stall = 1'b0;
		error_count = 0;
		cycle_count = 0;
		for (int i = 0; i < 256; i++) begin
			sub_table[i] = affine_of_inverse(8'(i));
		end
		for (int k = 0; k < KeyCount; k++) begin
			key_sched[k] = '0;
		end
		arst_n = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: the FIPS-197 appendix C.1 schedule and vector first.
		push_word(OP_LOAD, 4'd0, 64'h0001020304050607, 64'h08090a0b0c0d0e0f);
		push_word(OP_LOAD, 4'd1, 64'hd6aa74fdd2af72fa, 64'hdaa678f1d6ab76fe);
		push_word(OP_LOAD, 4'd2, 64'hb692cf0b643dbdf1, 64'hbe9bc5006830b3fe);
		push_word(OP_LOAD, 4'd3, 64'hb6ff744ed2c2c9bf, 64'h6c590cbf0469bf41);
		push_word(OP_LOAD, 4'd4, 64'h47f7f7bc95353e03, 64'hf96c32bcfd058dfd);
		push_word(OP_LOAD, 4'd5, 64'h3caaa3e8a99f9deb, 64'h50f3af57adf622aa);
		push_word(OP_LOAD, 4'd6, 64'h5e390f7df7a69296, 64'ha7553dc10aa31f6b);
		push_word(OP_LOAD, 4'd7, 64'h14f9701ae35fe28c, 64'h440adf4d4ea9c026);
		push_word(OP_LOAD, 4'd8, 64'h47438735a41c65b9, 64'he016baf4aebf7ad2);
		push_word(OP_LOAD, 4'd9, 64'h549932d1f0855768, 64'h1093ed9cbe2c974e);
		push_word(OP_LOAD, 4'd10, 64'h13111d7fe3944a17, 64'hf307a78b4d2b30c5);
		push_word(OP_ENCRYPT, 4'd0, 64'h0011223344556677, 64'h8899aabbccddeeff);
		// Extremes of the plaintext, an ignored key index on an encrypt,
		// and loads with out-of-range indexes that must be dropped.
		push_word(OP_ENCRYPT, 4'd15, 64'h0, 64'h0);
		push_word(OP_ENCRYPT, 4'd11, '1, '1);
		push_word(OP_LOAD, 4'd11, '1, '1);
		push_word(OP_LOAD, 4'd15, '1, '1);
		push_word(OP_LOAD, 4'd13, 64'h0, 64'h0);
		push_word(OP_ENCRYPT, 4'd0, 64'h8000000000000000, 64'h0000000000000001);
		// Key extremes: all-zero and all-one round key 10.
		push_word(OP_LOAD, 4'd10, 64'h0, 64'h0);
		push_word(OP_ENCRYPT, 4'd0, rand64(), rand64());
		push_word(OP_LOAD, 4'd10, '1, '1);
		push_word(OP_ENCRYPT, 4'd0, rand64(), rand64());

		// Random: fresh schedules now and then, single key rewrites, stray
		// out-of-range loads, and mostly encrypts with random plaintext.
		for (int n = 0; n < 680; n++) begin
			int pick;
			pick = $urandom_range(0, 99);
			if (pick < 2) begin
				push_schedule({rand64(), rand64()});
			end else if (pick < 12) begin
				push_word(OP_LOAD, 4'($urandom_range(0, 10)), rand64(), rand64());
			end else if (pick < 16) begin
				push_word(OP_LOAD, 4'($urandom_range(11, 15)), rand64(), rand64());
			end else begin
				push_word(OP_ENCRYPT, 4'($urandom_range(0, 15)), rand64(), rand64());
			end
		end

		wait (pending_words.size() == 0);
		@(posedge clk);
		while (in_valid || expected_cipher.size() > 0) begin
			@(posedge clk);
		end
		repeat (30) @(posedge clk);
		if (error_count == 0) begin
			$display("aes128_encrypt_block verification clean");
		end else begin
			$display("aes128_encrypt_block verification failed");
		end
		$finish;
	end

endmodule

// ===== files.f =====
src/aes_pkg.sv
src/aes_ram.sv
src/aes128_encrypt_block.sv
bench/aes128_encrypt_block_test.sv
